// ===== design/fas_pkg.sv =====
// Shared types and constants for the truncating single-precision adder.
`default_nettype none
package fas_pkg;
  localparam int unsigned SigW = 24;
  localparam int unsigned ExpW = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned MagW = 31;
  localparam int unsigned DiffW = 8;

  // Control carried down the pipeline with each item.
  typedef struct packed {
    logic valid;
    logic zero;
    logic sgn;
    logic eff_sub;
  } ctl_t;
endpackage
`default_nettype wire

// ===== design/float32_add_sub_truncating.sv =====
// Top level of the truncating single-precision adder and subtractor.
//
// Usage: drive operand_a_i, operand_b_i and mode_i (0 add, 1 subtract) and
// pulse start_i. busy_o is always low, so an item is taken at every edge
// where start_i is high: one item per cycle sustained.
// The result is driven on result_o and exponent_wrapped_o from the pack
// stage register, marked by done_o high for one cycle.
// Four register stages: order, align, add, normalize and pack.
// The receiver cannot stall; results must be taken when done_o is high.
// Reset clears all valid bits, so no stray result follows reset.
`default_nettype none
module float32_add_sub_truncating (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic        mode_i,
  output logic        done_o,
  output logic [31:0] result_o,
  output logic        exponent_wrapped_o
);
  fas_pkg::ctl_t ctl;
  logic [fas_pkg::ExpW-1:0] exp_w;
  logic [fas_pkg::SigW-1:0] sigb, aligned;
  logic borrow;

  assign busy_o = 1'b0;

  fas_align u_align (
    .clk_i, .rst_ni, .start_i, .operand_a_i, .operand_b_i, .mode_i,
    .ctl_o(ctl), .exp_o(exp_w), .sigb_o(sigb), .aligned_o(aligned),
    .borrow_o(borrow)
  );

  fas_norm u_norm (
    .clk_i, .rst_ni, .ctl_i(ctl), .exp_i(exp_w), .sigb_i(sigb),
    .aligned_i(aligned), .borrow_i(borrow), .done_o, .result_o,
    .exponent_wrapped_o
  );

  // Every start emerges as done once it has passed through the pipeline.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##4 done_o) else $error("lost item");
  a_nospur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 4)) else $error("spurious result");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy raised");
endmodule
`default_nettype wire

// ===== design/fas_align.sv =====
// Stage one and two: order operands by magnitude, then align the smaller one.
`default_nettype none
module fas_align (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [31:0]              operand_a_i,
  input  logic [31:0]              operand_b_i,
  input  logic                     mode_i,
  output fas_pkg::ctl_t            ctl_o,
  output logic [fas_pkg::ExpW-1:0] exp_o,
  output logic [fas_pkg::SigW-1:0] sigb_o,
  output logic [fas_pkg::SigW-1:0] aligned_o,
  output logic                     borrow_o
);
  logic [31:0] b_eff, big, sml;
  fas_pkg::ctl_t ctl1_d, ctl1_q;
  logic [fas_pkg::ExpW-1:0] eb_q, es_q;
  logic [fas_pkg::FracW-1:0] fb_q, fs_q;
  logic [fas_pkg::DiffW-1:0] d;
  logic [fas_pkg::SigW-1:0] sigs;
  logic [fas_pkg::SigW:0] ext;
  fas_pkg::ctl_t ctl2_q;
  logic [fas_pkg::ExpW-1:0] exp2_q;
  logic [fas_pkg::SigW-1:0] sigb2_q, al2_q;
  logic bor2_q;

  // Order operands; equal magnitudes pick b.
  always_comb begin
    b_eff = operand_b_i ^ {mode_i, 31'd0};
    if (operand_a_i[30:0] > b_eff[30:0]) begin
      big = operand_a_i;
      sml = b_eff;
    end else begin
      big = b_eff;
      sml = operand_a_i;
    end
    ctl1_d.valid = start_i;
    ctl1_d.eff_sub = big[31] ^ sml[31];
    ctl1_d.sgn = big[31];
    ctl1_d.zero = ctl1_d.eff_sub && (big[30:0] == sml[30:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else begin
      ctl1_q <= ctl1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eb_q <= big[30:23];
    es_q <= sml[30:23];
    fb_q <= big[22:0];
    fs_q <= sml[22:0];
  end

  // Shift the smaller significand, keep the top shifted-out bit as borrow.
  always_comb begin
    d = eb_q - es_q;
    sigs = {1'b1, fs_q};
    ext = (d > 8'd24) ? '0 : ({sigs, 1'b0} >> d[4:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else begin
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    exp2_q <= eb_q;
    sigb2_q <= {1'b1, fb_q};
    al2_q <= ext[fas_pkg::SigW:1];
    bor2_q <= ext[0];
  end

  assign ctl_o = ctl2_q;
  assign exp_o = exp2_q;
  assign sigb_o = sigb2_q;
  assign aligned_o = al2_q;
  assign borrow_o = bor2_q;
endmodule
`default_nettype wire

// ===== design/fas_norm.sv =====
// Stage three and four: add or subtract, then normalize and pack.
`default_nettype none
module fas_norm (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fas_pkg::ctl_t            ctl_i,
  input  logic [fas_pkg::ExpW-1:0] exp_i,
  input  logic [fas_pkg::SigW-1:0] sigb_i,
  input  logic [fas_pkg::SigW-1:0] aligned_i,
  input  logic                     borrow_i,
  output logic                     done_o,
  output logic [31:0]              result_o,
  output logic                     exponent_wrapped_o
);
  logic [fas_pkg::SigW:0] sum;
  fas_pkg::ctl_t ctl3_q;
  logic [fas_pkg::SigW:0] sum3_q;
  logic [fas_pkg::ExpW-1:0] exp3_q;
  logic [fas_pkg::SigW-1:0] sig;
  logic [4:0] lz;
  logic [9:0] e;
  logic wrap, zero;
  logic done_q;
  logic [31:0] res_q;
  logic wrap_q;

  // Add or subtract the aligned significands.
  always_comb begin
    if (ctl_i.eff_sub) begin
      sum = {1'b0, sigb_i} - {1'b0, aligned_i} - {24'd0, borrow_i};
    end else begin
      sum = {1'b0, sigb_i} + {1'b0, aligned_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else begin
      ctl3_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sum3_q <= sum;
    exp3_q <= exp_i;
  end

  // Count leading zeros and renormalize.
  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (sum3_q[i]) lz = 5'(23 - i);
    end
    zero = ctl3_q.zero || (ctl3_q.eff_sub && (sum3_q[23:0] == '0));
    if (!ctl3_q.eff_sub && sum3_q[24]) begin
      sig = sum3_q[24:1];
      e = {2'b00, exp3_q} + 10'd1;
    end else begin
      sig = sum3_q[23:0] << lz;
      e = {2'b00, exp3_q} - {5'd0, lz};
    end
    wrap = e[9] || e[8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl3_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= zero ? 32'd0 : {ctl3_q.sgn, e[7:0], sig[22:0]};
    wrap_q <= zero ? 1'b0 : wrap;
  end

  assign done_o = done_q;
  assign result_o = res_q;
  assign exponent_wrapped_o = wrap_q;
endmodule
`default_nettype wire
